### design/abs_pkg.sv
// shared types and constants of the alternating bit sender
// no dependencies

package abs_pkg;

  localparam int unsigned PayloadW = 160;
  localparam int unsigned SumW     = 8;
  localparam int unsigned EntryW   = PayloadW + SumW;
  localparam int unsigned TimerW   = 16;

  localparam logic [7:0]        AckField     = 8'h00;
  localparam logic [TimerW-1:0] TimeoutReset = 16'd20;

  typedef enum logic [1:0] {
    CMD_MSG = 2'd0,
    CMD_ACK = 2'd1,
    CMD_TMO = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_MISMATCH    = 3'd1,
    ST_CHECKSUM    = 3'd2,
    ST_NOT_WAITING = 3'd3,
    ST_FULL        = 3'd4
  } status_e;

  // where the packet of a beat comes from
  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_INPUT = 2'd1,
    SRC_QUEUE = 2'd2,
    SRC_LAST  = 2'd3
  } src_e;

  // control carried from the decode stage to the result stage
  typedef struct packed {
    src_e            src;
    logic            seq;
    logic [SumW-1:0] sum;
    logic            stop;
    status_e         status;
  } s1_ctrl_t;

endpackage

### design/alternating_bit_sender_top.sv
// alternating bit sender: an input beat goes through the decode stage, registered
// together with the queue ram read, and then the result register; one beat per
// cycle is sustained while the result side keeps up, set by the decode stage
// with its single queue ram access. reset leaves the sender idle with an empty
// queue, sequence bits 0 and timeout 20; queue entries need no clearing pass
// depends on abs_pkg and abs_ram

module alternating_bit_sender_top
  import abs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TimerW-1:0]   cfg_data_i,
  // event input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [63:0]         payload_low_i,
  input  logic [63:0]         payload_mid_i,
  input  logic [31:0]         payload_high_i,
  input  logic [7:0]          ack_seq_field_i,
  input  logic [7:0]          ack_number_i,
  input  logic [7:0]          ack_checksum_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                send_valid_o,
  output logic                send_seq_o,
  output logic [7:0]          send_ack_o,
  output logic [7:0]          send_checksum_o,
  output logic [63:0]         send_payload_low_o,
  output logic [63:0]         send_payload_mid_o,
  output logic [31:0]         send_payload_high_o,
  output logic                timer_start_o,
  output logic [TimerW-1:0]   timer_load_o,
  output logic                timer_stop_o,
  output logic [2:0]          status_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // 8-bit sum over the 20 payload bytes, as four groups of five
  function automatic logic [SumW-1:0] byte_sum(input logic [PayloadW-1:0] w);
    logic [SumW-1:0] part [4];
    logic [SumW-1:0] s;
    for (int g = 0; g < 4; g++) begin
      part[g] = '0;
      for (int b = 0; b < 5; b++) begin
        part[g] = part[g] + w[(g*5+b)*8 +: 8];
      end
    end
    s = (part[0] + part[1]) + (part[2] + part[3]);
    return s;
  endfunction

  // configuration register
  logic [TimerW-1:0] timeout_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  // sender state
  logic            waiting_q, waiting_d;
  logic            next_seq_q, next_seq_d;
  logic            cur_seq_q, cur_seq_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  // pipeline registers
  logic                s1_valid_q;
  s1_ctrl_t            s1_ctrl_q, s1_ctrl_d;
  logic [PayloadW-1:0] s1_payload_q;
  logic                out_valid_q;
  logic [PayloadW-1:0] last_payload_q;
  logic [SumW-1:0]     last_sum_q;

  logic                in_acc;
  logic                s1_move;
  logic [PayloadW-1:0] in_payload;
  logic [SumW-1:0]     in_bsum;
  logic [SumW-1:0]     msg_sum;
  logic [SumW-1:0]     ack_sum;
  logic                ram_we;
  logic                ram_re;
  logic [EntryW-1:0]   ram_rdata;
  cmd_e                cmd;

  assign in_payload = {payload_high_i, payload_mid_i, payload_low_i};
  assign in_bsum    = byte_sum(in_payload);
  assign msg_sum    = in_bsum + SumW'(next_seq_q);
  assign ack_sum    = in_bsum + ack_seq_field_i + ack_number_i;
  assign cmd        = cmd_e'(command_i);

  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // decode stage: checks, queue bookkeeping and memory access
  always_comb begin
    waiting_d  = waiting_q;
    next_seq_d = next_seq_q;
    cur_seq_d  = cur_seq_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    s1_ctrl_d  = '{src: SRC_NONE, seq: 1'b0, sum: '0, stop: 1'b0, status: ST_OK};
    if (in_acc) begin
      unique case (cmd)
        CMD_MSG: begin
          if (count_q == CntW'(QUEUE_DEPTH)) begin
            s1_ctrl_d.status = ST_FULL;
          end else begin
            next_seq_d = ~next_seq_q;
            if (waiting_q) begin
              ram_we  = 1'b1;
              tail_d  = wrap_inc(tail_q);
              count_d = count_q + 1'b1;
            end else begin
              // idle implies an empty queue: send straight away
              s1_ctrl_d.src = SRC_INPUT;
              s1_ctrl_d.seq = next_seq_q;
              s1_ctrl_d.sum = msg_sum;
              waiting_d     = 1'b1;
              cur_seq_d     = next_seq_q;
            end
          end
        end
        CMD_ACK: begin
          if (ack_number_i != {7'd0, cur_seq_q}) begin
            s1_ctrl_d.status = ST_MISMATCH;
          end else if (ack_sum != ack_checksum_i) begin
            s1_ctrl_d.status = ST_CHECKSUM;
          end else if (!waiting_q) begin
            s1_ctrl_d.status = ST_NOT_WAITING;
          end else begin
            s1_ctrl_d.stop = 1'b1;
            if (count_q != '0) begin
              // queued sequence bits alternate, so the head follows the last sent
              ram_re        = 1'b1;
              s1_ctrl_d.src = SRC_QUEUE;
              s1_ctrl_d.seq = ~cur_seq_q;
              cur_seq_d     = ~cur_seq_q;
              head_d        = wrap_inc(head_q);
              count_d       = count_q - 1'b1;
            end else begin
              waiting_d = 1'b0;
            end
          end
        end
        CMD_TMO: begin
          if (!waiting_q) begin
            s1_ctrl_d.status = ST_NOT_WAITING;
          end else begin
            s1_ctrl_d.src = SRC_LAST;
            s1_ctrl_d.seq = cur_seq_q;
          end
        end
        default: begin
          s1_ctrl_d.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q  <= 1'b0;
      next_seq_q <= 1'b0;
      cur_seq_q  <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
    end else begin
      waiting_q  <= waiting_d;
      next_seq_q <= next_seq_d;
      cur_seq_q  <= cur_seq_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
    end
  end

  // queue memory: payload and checksum per entry
  abs_ram #(
    .Width (EntryW),
    .Depth (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i ({msg_sum, in_payload}),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // stage 1 occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ctrl_q    <= s1_ctrl_d;
      s1_payload_q <= in_payload;
    end
  end

  // packet selection for the result beat
  logic [PayloadW-1:0] pkt_payload;
  logic [SumW-1:0]     pkt_sum;
  logic                pkt_send;

  always_comb begin
    pkt_payload = '0;
    pkt_sum     = '0;
    pkt_send    = 1'b1;
    case (s1_ctrl_q.src)
      SRC_INPUT: begin
        pkt_payload = s1_payload_q;
        pkt_sum     = s1_ctrl_q.sum;
      end
      SRC_QUEUE: begin
        pkt_payload = ram_rdata[PayloadW-1:0];
        pkt_sum     = ram_rdata[EntryW-1:PayloadW];
      end
      SRC_LAST: begin
        pkt_payload = last_payload_q;
        pkt_sum     = last_sum_q;
      end
      default: begin
        pkt_send = 1'b0;
      end
    endcase
  end

  // last sent packet, updated as each sending beat leaves stage 1
  always_ff @(posedge clk_i) begin
    if (s1_move && pkt_send) begin
      last_payload_q <= pkt_payload;
      last_sum_q     <= pkt_sum;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      send_valid_o        <= pkt_send;
      send_seq_o          <= pkt_send & s1_ctrl_q.seq;
      send_checksum_o     <= pkt_sum;
      send_payload_low_o  <= pkt_payload[63:0];
      send_payload_mid_o  <= pkt_payload[127:64];
      send_payload_high_o <= pkt_payload[159:128];
      timer_start_o       <= pkt_send;
      timer_load_o        <= pkt_send ? timeout_q : '0;
      timer_stop_o        <= s1_ctrl_q.stop;
      status_o            <= s1_ctrl_q.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign send_ack_o  = AckField;

  // checks on queue bookkeeping and the held memory read
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !waiting_q |-> count_q == '0)
    else $error("idle sender with queued packets");

  a_ram_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("queue read and write in one cycle");

  a_read_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |-> !ram_re)
    else $error("queue read data overwritten while stage 1 stalls");

  a_dequeue_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (s1_valid_q && s1_ctrl_q.src == SRC_QUEUE))
    else $error("queue read without matching stage 1 beat");

endmodule

### design/abs_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies

module abs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### verif/tb_alternating_bit_sender_top.sv
// testbench of alternating_bit_sender_top: directed table then weighted random
// events, each result checked against an in-bench model of the sender
// depends on abs_pkg and the design files of alternating_bit_sender_top

module tb_alternating_bit_sender_top;
  import abs_pkg::*;

  localparam int QDepth     = 16;
  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 80;
  localparam int PhaseItems = 420;

  // one input event
  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] plo;
    logic [63:0] pmid;
    logic [31:0] phi;
    logic [7:0]  aseq;
    logic [7:0]  anum;
    logic [7:0]  acks;
  } evt_t;

  // one result beat
  typedef struct packed {
    logic        send_valid;
    logic        send_seq;
    logic [7:0]  send_ack;
    logic [7:0]  send_checksum;
    logic [63:0] plo;
    logic [63:0] pmid;
    logic [31:0] phi;
    logic        timer_start;
    logic [15:0] timer_load;
    logic        timer_stop;
    status_e     status;
  } outcome_t;

  // framed packet as held in the send queue
  typedef struct packed {
    logic [159:0] data;
    logic         seq;
    logic [7:0]   sum;
  } frame_t;

  // directed row; auto_hdr fills in a matching ack number and checksum
  typedef struct {
    evt_t    ev;
    bit      auto_hdr;
    int      reps;
    bit      has_st;
    status_e want;
  } dir_row_t;

  bit          clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  evt_t        drv;
  logic        out_valid;
  logic        out_ready;
  logic        send_valid;
  logic        send_seq;
  logic [7:0]  send_ack;
  logic [7:0]  send_checksum;
  logic [63:0] send_plo;
  logic [63:0] send_pmid;
  logic [31:0] send_phi;
  logic        timer_start;
  logic [15:0] timer_load;
  logic        timer_stop;
  logic [2:0]  status;

  // sender model state
  logic        waiting;
  logic        next_seq;
  logic        cur_seq;
  frame_t      last_frame;
  frame_t      frame_q[$];
  logic [15:0] tmo_ticks;

  outcome_t    outcome_q[$];
  outcome_t    seen;
  dir_row_t    dir_tab[$];

  int errors;
  int cycles;
  int n_msg, n_ack, n_tmo, n_nop, n_full, n_sent;
  bit calm;
  bit hold_req;
  int hold_left;
  logic [15:0] last_cfg;

  alternating_bit_sender_top #(
    .QUEUE_DEPTH(QDepth)
  ) DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .command_i          (drv.cmd),
    .payload_low_i      (drv.plo),
    .payload_mid_i      (drv.pmid),
    .payload_high_i     (drv.phi),
    .ack_seq_field_i    (drv.aseq),
    .ack_number_i       (drv.anum),
    .ack_checksum_i     (drv.acks),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .send_valid_o       (send_valid),
    .send_seq_o         (send_seq),
    .send_ack_o         (send_ack),
    .send_checksum_o    (send_checksum),
    .send_payload_low_o (send_plo),
    .send_payload_mid_o (send_pmid),
    .send_payload_high_o(send_phi),
    .timer_start_o      (timer_start),
    .timer_load_o       (timer_load),
    .timer_stop_o       (timer_stop),
    .status_o           (status)
  );

  always #1 clk = ~clk;

  // 8-bit sum of the 20 payload bytes
  function automatic logic [7:0] frame_sum(input logic [159:0] p);
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < 20; i++) s += p[8*i +: 8];
    return s;
  endfunction

  // put a frame on the wire and arm the timer
  function automatic outcome_t launch(input frame_t f);
    outcome_t o;
    o = '0;
    o.send_valid    = 1'b1;
    o.send_seq      = f.seq;
    o.send_checksum = f.sum;
    o.plo           = f.data[63:0];
    o.pmid          = f.data[127:64];
    o.phi           = f.data[159:128];
    o.timer_start   = 1'b1;
    o.timer_load    = tmo_ticks;
    last_frame = f;
    cur_seq    = f.seq;
    waiting    = 1'b1;
    return o;
  endfunction

  // advance the sender model by one event
  function automatic outcome_t sender_step(input evt_t ev);
    outcome_t     o;
    frame_t       f;
    logic [159:0] p;
    logic [7:0]   s;
    o = '0;
    p = {ev.phi, ev.pmid, ev.plo};
    case (ev.cmd)
      CMD_MSG: begin
        if (frame_q.size() >= QDepth) begin
          o.status = ST_FULL;
        end else begin
          f.data = p;
          f.seq  = next_seq;
          f.sum  = frame_sum(p) + next_seq;
          frame_q.push_back(f);
          next_seq = ~next_seq;
          if (!waiting) o = launch(frame_q.pop_front());
          o.status = ST_OK;
        end
      end
      CMD_ACK: begin
        s = frame_sum(p) + ev.aseq + ev.anum;
        if (ev.anum != {7'b0, cur_seq}) begin
          o.status = ST_MISMATCH;
        end else if (s != ev.acks) begin
          o.status = ST_CHECKSUM;
        end else if (!waiting) begin
          o.status = ST_NOT_WAITING;
        end else begin
          waiting = 1'b0;
          if (frame_q.size() > 0) o = launch(frame_q.pop_front());
          o.timer_stop = 1'b1;
          o.status     = ST_OK;
        end
      end
      CMD_TMO: begin
        if (!waiting) begin
          o.status = ST_NOT_WAITING;
        end else begin
          o = launch(last_frame);
          o.status = ST_OK;
        end
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  // ack header that passes every check against the current state
  function automatic evt_t good_hdr(input evt_t ev);
    evt_t e;
    e = ev;
    e.anum = {7'b0, cur_seq};
    e.acks = frame_sum({e.phi, e.pmid, e.plo}) + e.aseq + e.anum;
    return e;
  endfunction

  function automatic void add_row(cmd_e cmd, logic [63:0] lo, logic [63:0] mid,
                                  logic [31:0] hi, logic [7:0] aseq, logic [7:0] anum,
                                  logic [7:0] acks, bit auto_hdr, int reps,
                                  bit has_st, status_e want);
    dir_row_t r;
    r.ev       = '{cmd, lo, mid, hi, aseq, anum, acks};
    r.auto_hdr = auto_hdr;
    r.reps     = reps;
    r.has_st   = has_st;
    r.want     = want;
    dir_tab.push_back(r);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // weighted random event: well-formed traffic plus some noise
  function automatic evt_t rand_event(int msg_w, int ack_w);
    evt_t e;
    int   r;
    e = '{CMD_MSG, rand64(), rand64(), $urandom, 8'($urandom), 8'($urandom),
          8'($urandom)};
    r = $urandom_range(0, 99);
    if (r < msg_w) begin
      e.cmd = CMD_MSG;
    end else if (r < msg_w + ack_w) begin
      e.cmd = CMD_ACK;
      e = good_hdr(e);
    end else if (r < msg_w + ack_w + 10) begin
      e.cmd = CMD_TMO;
    end else begin
      case ($urandom_range(0, 3))
        0: e.cmd = CMD_ACK;
        1: begin
          e.cmd = CMD_ACK;
          e = good_hdr(e);
          e.acks ^= 8'($urandom_range(1, 255));
        end
        2: begin
          e.cmd = CMD_ACK;
          e = good_hdr(e);
          e.anum = {7'b0, ~cur_seq};
          e.acks = frame_sum({e.phi, e.pmid, e.plo}) + e.aseq + e.anum;
        end
        default: e.cmd = CMD_NOP;
      endcase
    end
    return e;
  endfunction

  function automatic void check(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s expected %h got %h", name, exp, act);
      errors++;
    end
  endfunction

  // offer one beat, then update the model once it is taken
  task automatic offer(input evt_t ev, input bit has_st, input status_e want);
    outcome_t o;
    @(negedge clk);
    drv      <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    o = sender_step(ev);
    if (has_st) o.status = want;
    outcome_q.push_back(o);
    case (ev.cmd)
      CMD_MSG: n_msg++;
      CMD_ACK: n_ack++;
      CMD_TMO: n_tmo++;
      default: n_nop++;
    endcase
    if (o.status == ST_FULL) n_full++;
    if (o.send_valid) n_sent++;
  endtask

  // random input gap
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 99) < 10) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    tmo_ticks = v;
    last_cfg  = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int msg_w, input int ack_w);
    evt_t e;
    int   done;
    done = 0;
    while (done < n) begin
      e = rand_event(msg_w, ack_w);
      sender_gap();
      offer(e, 1'b0, ST_OK);
      if (e.cmd != CMD_NOP) done++;
    end
  endtask

  // result side: random stalls, and a long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        $error("result beat with no expectation pending, status %0d", status);
        errors++;
      end else begin
        seen = outcome_q.pop_front();
        check("send_valid", 64'(seen.send_valid), 64'(send_valid));
        check("send_seq", 64'(seen.send_seq), 64'(send_seq));
        check("send_ack", 64'(seen.send_ack), 64'(send_ack));
        check("send_checksum", 64'(seen.send_checksum), 64'(send_checksum));
        check("send_payload_low", seen.plo, send_plo);
        check("send_payload_mid", seen.pmid, send_pmid);
        check("send_payload_high", 64'(seen.phi), 64'(send_phi));
        check("timer_start", 64'(seen.timer_start), 64'(timer_start));
        check("timer_load", 64'(seen.timer_load), 64'(timer_load));
        check("timer_stop", 64'(seen.timer_stop), 64'(timer_stop));
        check("status", 64'(seen.status), 64'(status));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("alternating_bit_sender_top verification failed");
      $finish;
    end
  end

  initial begin
    dir_row_t r;
    evt_t     e;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    drv       = '{CMD_NOP, 64'h0, 64'h0, 32'h0, 8'h0, 8'h0, 8'h0};
    errors    = 0;
    cycles    = 0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    waiting   = 1'b0;
    next_seq  = 1'b0;
    cur_seq   = 1'b0;
    last_frame = '0;
    tmo_ticks = 16'd20;
    last_cfg  = 16'd20;
    n_msg = 0; n_ack = 0; n_tmo = 0; n_nop = 0; n_full = 0; n_sent = 0;

    // directed events, timeout still at its reset value
    add_row(CMD_TMO, '0, '0, '0, 8'h00, 8'h00, 8'h00, 0, 1, 1, ST_NOT_WAITING);
    add_row(CMD_ACK, '0, '0, '0, 8'h00, 8'h00, 8'h00, 0, 1, 1, ST_NOT_WAITING);
    add_row(CMD_NOP, '1, '1, '1, 8'hff, 8'hff, 8'hff, 0, 1, 1, ST_OK);
    add_row(CMD_MSG, '0, '0, '0, 8'h00, 8'h00, 8'h00, 0, 1, 1, ST_OK);
    add_row(CMD_MSG, '1, '1, '1, 8'hff, 8'hff, 8'hff, 0, 1, 1, ST_OK);
    add_row(CMD_ACK, '0, '0, '0, 8'h00, 8'h01, 8'h01, 0, 1, 1, ST_MISMATCH);
    add_row(CMD_ACK, '0, '0, '0, 8'h00, 8'hff, 8'hff, 0, 1, 1, ST_MISMATCH);
    add_row(CMD_ACK, '0, '0, '0, 8'h00, 8'h00, 8'h01, 0, 1, 1, ST_CHECKSUM);
    add_row(CMD_TMO, '1, '1, '1, 8'hff, 8'hff, 8'hff, 0, 1, 1, ST_OK);
    add_row(CMD_ACK, '1, '1, '1, 8'hff, 8'h00, 8'h00, 1, 1, 1, ST_OK);
    add_row(CMD_ACK, '0, '0, '0, 8'h00, 8'h00, 8'h00, 1, 1, 1, ST_OK);
    add_row(CMD_TMO, '0, '0, '0, 8'h00, 8'h00, 8'h00, 0, 1, 1, ST_NOT_WAITING);
    add_row(CMD_ACK, 64'h0123456789abcdef, '0, '0, 8'h5a, 8'h00, 8'h00, 1, 1, 1,
            ST_NOT_WAITING);
    // one goes out at once, the rest fill the queue
    add_row(CMD_MSG, {8{8'ha5}}, {8{8'h5a}}, {4{8'hc3}}, 8'h00, 8'h00, 8'h00, 0, 17, 0,
            ST_OK);
    add_row(CMD_MSG, {8{8'h5a}}, {8{8'ha5}}, {4{8'h3c}}, 8'h00, 8'h00, 8'h00, 0, 1, 1,
            ST_FULL);
    add_row(CMD_TMO, '0, '0, '0, 8'h00, 8'h00, 8'h00, 0, 1, 0, ST_OK);
    add_row(CMD_ACK, 64'haaaa5555aaaa5555, 64'h5555aaaa5555aaaa, 32'hf0f00f0f, 8'h80,
            8'h00, 8'h00, 1, 1, 1, ST_OK);
    add_row(CMD_MSG, 64'h0123456789abcdef, 64'hfedcba9876543210, 32'h80000001, 8'h00,
            8'h00, 8'h00, 0, 1, 1, ST_OK);
    add_row(CMD_ACK, 64'h8000000000000000, 64'h1, 32'h80000000, 8'h7f, 8'h00, 8'h00,
            1, 1, 1, ST_OK);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      for (int k = 0; k < r.reps; k++) begin
        e = r.auto_hdr ? good_hdr(r.ev) : r.ev;
        sender_gap();
        offer(e, r.has_st, r.want);
      end
    end
    drain();

    // random phases over several timeout settings
    write_timeout(16'd1);
    run_phase(PhaseItems, 45, 35);
    drain();

    write_timeout(16'hffff);
    hold_req = 1'b1;
    run_phase(PhaseItems, 60, 20);
    drain();

    write_timeout(16'd0);
    run_phase(PhaseItems, 30, 50);
    drain();

    write_timeout(16'($urandom_range(2, 65534)));
    calm = 1'b1;
    run_phase(PhaseItems, 45, 35);
    drain();
    calm = 1'b0;

    repeat (6) @(negedge clk);

    $display("covered %0d messages, %0d acks, %0d timeouts, %0d unused commands",
             n_msg, n_ack, n_tmo, n_nop);
    $display("%0d packets sent, %0d dropped on a full queue, last timeout %0d",
             n_sent, n_full, last_cfg);
    if (errors == 0) begin
      $display("alternating_bit_sender_top verification clean");
    end else begin
      $display("alternating_bit_sender_top verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/abs_pkg.sv
design/abs_ram.sv
design/alternating_bit_sender_top.sv
verif/tb_alternating_bit_sender_top.sv
